@@ sv/rlip_pkg.sv @@
package rlip_pkg;

    localparam int ADDR_W  = 32;
    localparam int TOTAL_W = 33;
    localparam int COUNT_W = 11;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_PICK  = 2'd2;

    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_INDEX_RANGE = 3'd1;
    localparam logic [2:0] STAT_FULL        = 3'd2;
    localparam logic [2:0] STAT_BAD_RANGE   = 3'd3;
    localparam logic [2:0] STAT_ORDER       = 3'd4;

    localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] range_first;
        logic [ADDR_W-1:0] range_last;
        logic [ADDR_W-1:0] pick_index;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  picked_address;
        logic [2:0]         status;
        logic [TOTAL_W-1:0] address_total;
        logic [COUNT_W-1:0] range_count;
    } out_item_t;

endpackage

@@ sv/range_list_index_picker.sv @@
// flow: clear and add go from accept through S_EXEC to S_RESULT, where the result is registered;
// pick also runs a binary search over the entries in S_SEARCH, then S_DONE, before S_RESULT
// throughput: one transaction in flight, s_ready returns in the same cycle as result valid;
// a transaction stays longer in S_RESULT while the previous result waits on m_ready
// reset: synchronous active-low aresetn empties the table and zeroes the total;
// entry memory contents are not cleared, only entries below the count are read
module range_list_index_picker
    import rlip_pkg::*;
#(
    parameter int MAX_RANGES = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int EW = TOTAL_W + ADDR_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_DONE   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    in_item_t           item_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [ADDR_W-1:0]  tail_first_reg, tail_first_next;
    logic [ADDR_W-1:0]  tail_last_reg, tail_last_next;
    logic [AW-1:0]      lo_reg, lo_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      mid_reg, mid_next;
    out_item_t          res_reg, res_next;
    out_item_t          m_data_reg;
    logic               m_valid_reg;

    logic [EW-1:0] entry_mem [MAX_RANGES];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [TOTAL_W-1:0] rd_prefix;
    logic [ADDR_W-1:0]  rd_first;
    logic [TOTAL_W-1:0] idx33;
    logic [TOTAL_W-1:0] tail_reach;
    logic [AW:0]        span;
    logic [AW-1:0]      step_lo, step_hi;
    logic [TOTAL_W-1:0] offset;
    logic [CW+10:0]     cnt_ext;

    assign rd_prefix = rd_data_reg[EW-1:ADDR_W];
    assign rd_first  = rd_data_reg[ADDR_W-1:0];
    assign idx33     = {1'b0, item_reg.pick_index};
    assign tail_reach = {1'b0, tail_last_reg} + TOTAL_W'(1);
    assign offset    = idx33 - rd_prefix;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        tail_first_next = tail_first_reg;
        tail_last_next  = tail_last_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        res_next        = res_reg;
        rd_addr         = mid_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = {total_reg, item_reg.range_first};
        span            = '0;
        step_lo         = lo_reg;
        step_hi         = hi_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_next.picked_address = '0;
                res_next.status         = STAT_OK;
                state_next              = S_RESULT;
                case (item_reg.mode)
                    MODE_CLEAR: begin
                        count_next = '0;
                        total_next = '0;
                    end
                    MODE_ADD: begin
                        if (item_reg.range_first > item_reg.range_last) begin
                            res_next.status = STAT_BAD_RANGE;
                        end else if (count_reg != '0
                                     && item_reg.range_first < tail_first_reg) begin
                            res_next.status = STAT_ORDER;
                        end else if (count_reg != '0 && (tail_last_reg == ALL_ONES
                                     || tail_reach >= {1'b0, item_reg.range_first})) begin
                            if (item_reg.range_last > tail_last_reg) begin
                                total_next = total_reg
                                    + {1'b0, item_reg.range_last - tail_last_reg};
                                tail_last_next = item_reg.range_last;
                            end
                        end else if (count_reg >= MAX_CNT) begin
                            res_next.status = STAT_FULL;
                        end else begin
                            wr_en           = 1'b1;
                            total_next      = total_reg
                                + {1'b0, item_reg.range_last - item_reg.range_first}
                                + TOTAL_W'(1);
                            tail_first_next = item_reg.range_first;
                            tail_last_next  = item_reg.range_last;
                            count_next      = count_reg + CW'(1);
                        end
                    end
                    MODE_PICK: begin
                        if (idx33 >= total_reg) begin
                            res_next.status = STAT_INDEX_RANGE;
                        end else begin
                            step_hi  = count_reg[AW-1:0] - AW'(1);
                            lo_next  = '0;
                            hi_next  = step_hi;
                            span     = {1'b0, step_hi} + (AW+1)'(1);
                            mid_next = span[AW:1];
                            if (step_hi == '0) begin
                                rd_addr    = '0;
                                state_next = S_DONE;
                            end else begin
                                rd_addr    = span[AW:1];
                                state_next = S_SEARCH;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SEARCH: begin
                if (rd_prefix <= idx33) begin
                    step_lo = mid_reg;
                end else begin
                    step_hi = mid_reg - AW'(1);
                end
                lo_next  = step_lo;
                hi_next  = step_hi;
                span     = {1'b0, step_hi} - {1'b0, step_lo} + (AW+1)'(1);
                mid_next = step_lo + span[AW:1];
                if (step_lo < step_hi) begin
                    rd_addr = step_lo + span[AW:1];
                end else begin
                    rd_addr    = step_lo;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                res_next.picked_address = rd_first + offset[ADDR_W-1:0];
                res_next.status         = STAT_OK;
                state_next              = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        cnt_ext                = {11'd0, count_next};
        res_next.address_total = total_next;
        res_next.range_count   = cnt_ext[COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            if (state_reg == S_RESULT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        tail_first_reg <= tail_first_next;
        tail_last_reg  <= tail_last_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        res_reg        <= res_next;
        if (state_reg == S_RESULT && (!m_valid_reg || m_ready)) begin
            m_data_reg <= res_reg;
        end
    end

endmodule

@@ sv/rlip_checker.sv @@
module rlip_checker
    import rlip_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {1'b1, {(TOTAL_W-1){1'b0}}};

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one transaction at a time
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STAT_OK || m_data.status == STAT_INDEX_RANGE
                     || m_data.status == STAT_FULL || m_data.status == STAT_BAD_RANGE
                     || m_data.status == STAT_ORDER))
        else $error("bad status code");

    a_err_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_OK |-> m_data.picked_address == '0)
        else $error("address on error");

    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.address_total <= TOTAL_MAX)
        else $error("total beyond address space");

endmodule

bind range_list_index_picker rlip_checker u_rlip_checker (.*);

@@ sim/range_list_index_picker_test.sv @@
`timescale 1ns / 100ps

module range_list_index_picker_test
    import rlip_pkg::*;
();

    localparam int TABLE_DEPTH = 1024;
    localparam int REQUEST_GOAL = 1550;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    class range_table_model;
        logic [ADDR_W-1:0]  first_addr [TABLE_DEPTH];
        logic [ADDR_W-1:0]  last_addr [TABLE_DEPTH];
        logic [TOTAL_W-1:0] prefix [TABLE_DEPTH];
        int unsigned        entries = 0;
        logic [TOTAL_W-1:0] total = '0;
        out_item_t          expected_results [$];
        int                 mismatch_count = 0;

        function logic [2:0] add_range(input logic [ADDR_W-1:0] lo_addr,
                                       input logic [ADDR_W-1:0] hi_addr);
            int unsigned tail;
            if (lo_addr > hi_addr) begin
                return STAT_BAD_RANGE;
            end
            if (entries > 0) begin
                tail = entries - 1;
                if (lo_addr < first_addr[tail]) begin
                    return STAT_ORDER;
                end
                if (last_addr[tail] == ALL_ONES ||
                    {1'b0, last_addr[tail]} + 33'd1 >= {1'b0, lo_addr}) begin
                    if (hi_addr > last_addr[tail]) begin
                        total = total + {1'b0, hi_addr - last_addr[tail]};
                        last_addr[tail] = hi_addr;
                    end
                    return STAT_OK;
                end
            end
            if (entries >= TABLE_DEPTH) begin
                return STAT_FULL;
            end
            first_addr[entries] = lo_addr;
            last_addr[entries] = hi_addr;
            prefix[entries] = total;
            total = total + {1'b0, hi_addr - lo_addr} + 33'd1;
            entries++;
            return STAT_OK;
        endfunction

        function logic [2:0] pick_address(input logic [ADDR_W-1:0] idx,
                                          output logic [ADDR_W-1:0] addr);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            addr = '0;
            if (entries == 0 || {1'b0, idx} >= total) begin
                return STAT_INDEX_RANGE;
            end
            lo = 0;
            hi = entries - 1;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                if (prefix[mid] <= {1'b0, idx}) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            addr = first_addr[lo] + (idx - prefix[lo][ADDR_W-1:0]);
            return STAT_OK;
        endfunction

        function void note_request(input in_item_t req);
            out_item_t res;
            logic [ADDR_W-1:0] addr;
            res = '0;
            case (req.mode)
                MODE_CLEAR: begin
                    entries = 0;
                    total = '0;
                end
                MODE_ADD: begin
                    res.status = add_range(req.range_first, req.range_last);
                end
                MODE_PICK: begin
                    res.status = pick_address(req.pick_index, addr);
                    res.picked_address = addr;
                end
                default: begin
                end
            endcase
            res.address_total = total;
            res.range_count = entries[COUNT_W-1:0];
            expected_results.push_back(res);
        endfunction

        function void check_result(input out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction %p", got);
                mismatch_count++;
                return;
            end
            want = expected_results.pop_front();
            if (got.picked_address !== want.picked_address) begin
                $error("picked_address expected %h actual %h",
                       want.picked_address, got.picked_address);
                mismatch_count++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                mismatch_count++;
            end
            if (got.address_total !== want.address_total) begin
                $error("address_total expected %h actual %h",
                       want.address_total, got.address_total);
                mismatch_count++;
            end
            if (got.range_count !== want.range_count) begin
                $error("range_count expected %0d actual %0d",
                       want.range_count, got.range_count);
                mismatch_count++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    range_table_model table_model = new();
    int unsigned requests_sent = 0;
    int unsigned burst_left = 0;
    bit          ready_phase = 1'b0;
    int unsigned ready_left = 0;

    range_list_index_picker #(
        .MAX_RANGES(TABLE_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_phase = !ready_phase;
            ready_left = ready_phase ? $urandom_range(1, 40) : $urandom_range(1, 6);
        end
        ready_left = ready_left - 1;
        m_ready <= ready_phase;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            table_model.check_result(m_data);
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] clamp32(input longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? ALL_ONES : v[ADDR_W-1:0];
    endfunction

    task automatic issue_request(input logic [1:0] mode, input logic [ADDR_W-1:0] first,
                                 input logic [ADDR_W-1:0] last,
                                 input logic [ADDR_W-1:0] index);
        in_item_t req;
        int unsigned gap;
        req.mode = mode;
        req.range_first = first;
        req.range_last = last;
        req.pick_index = index;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        table_model.note_request(req);
        requests_sent++;
        burst_left--;
    endtask

    // hold the sender off until every pending result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (table_model.expected_results.size() != 0);
    endtask

    task automatic pick_random();
        longint unsigned idx;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (table_model.total != 0 && r < 6) begin
            idx = {$urandom(), $urandom()} % table_model.total;
        end else if (table_model.entries != 0 && r < 7) begin
            idx = table_model.prefix[$urandom_range(0, table_model.entries - 1)];
        end else if (table_model.total != 0 && r < 8) begin
            idx = table_model.total - 1;
        end else if (r < 9) begin
            idx = table_model.total;
        end else begin
            idx = $urandom();
        end
        issue_request(MODE_PICK, $urandom(), $urandom(), clamp32(idx));
    endtask

    task automatic add_run(input int count, input int append_pct, input int min_shift);
        longint unsigned first;
        longint unsigned last;
        longint unsigned tail_first;
        longint unsigned tail_last;
        int unsigned r;
        int unsigned other;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            other = (r >= append_pct) ? (r - append_pct) * 100 / (100 - append_pct) : 0;
            if (table_model.entries != 0) begin
                tail_first = table_model.first_addr[table_model.entries - 1];
                tail_last = table_model.last_addr[table_model.entries - 1];
            end
            if (table_model.entries == 0 || r < append_pct) begin
                first = (table_model.entries == 0) ? 0 : tail_last + 2;
                first = first + ($urandom() >> $urandom_range(min_shift, 31));
                last = first + ($urandom() >> $urandom_range(min_shift, 31));
                issue_request(MODE_ADD, clamp32(first), clamp32(last), $urandom());
            end else if (other < 45) begin
                // overlapping or touching the tail entry
                first = tail_first + ({$urandom(), $urandom()} % (tail_last + 2 - tail_first));
                last = first + ($urandom() >> $urandom_range(min_shift, 31));
                issue_request(MODE_ADD, clamp32(first), clamp32(last), $urandom());
            end else if (other < 60 && tail_first != 0) begin
                first = $urandom_range(0, tail_first - 1);
                last = first + ($urandom() >> $urandom_range(0, 31));
                issue_request(MODE_ADD, clamp32(first), clamp32(last), $urandom());
            end else if (other < 75) begin
                first = $urandom_range(1, ALL_ONES);
                last = $urandom_range(0, first - 1);
                issue_request(MODE_ADD, first[ADDR_W-1:0], last[ADDR_W-1:0], $urandom());
            end else if (other < 82) begin
                issue_request(MODE_UNUSED, $urandom(), $urandom(), $urandom());
            end else begin
                pick_random();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        issue_request(MODE_PICK, '0, '0, '0);
        issue_request(MODE_ADD, 32'd10, 32'd5, '0);
        issue_request(MODE_ADD, 32'd0, 32'd0, '0);
        issue_request(MODE_ADD, 32'd1, 32'd3, '0);
        issue_request(MODE_ADD, 32'd2, 32'd2, '0);
        issue_request(MODE_ADD, 32'd10, 32'd20, '0);
        issue_request(MODE_ADD, 32'd5, 32'd30, '0);
        issue_request(MODE_PICK, '0, '0, 32'd0);
        issue_request(MODE_PICK, '0, '0, 32'd3);
        issue_request(MODE_PICK, '0, '0, 32'd4);
        issue_request(MODE_PICK, '0, '0, 32'd14);
        issue_request(MODE_PICK, '0, '0, 32'd15);
        issue_request(MODE_PICK, '0, '0, ALL_ONES);
        issue_request(MODE_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES);
        issue_request(MODE_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES);
        issue_request(MODE_ADD, '0, ALL_ONES, '0);
        issue_request(MODE_PICK, '0, '0, ALL_ONES);
        issue_request(MODE_ADD, ALL_ONES, ALL_ONES, '0);
        issue_request(MODE_ADD, 32'd5, 32'd7, '0);
        drain_results();
        issue_request(MODE_CLEAR, '0, '0, '0);
        issue_request(MODE_ADD, ALL_ONES, ALL_ONES, '0);
        issue_request(MODE_ADD, 32'd0, 32'd0, '0);
        issue_request(MODE_PICK, '0, '0, 32'd0);
        issue_request(MODE_ADD, ALL_ONES, 32'd0, '0);

        // fill the table, then push past full
        issue_request(MODE_CLEAR, $urandom(), $urandom(), $urandom());
        while (table_model.entries < TABLE_DEPTH && requests_sent < 3000) begin
            add_run(1, 95, 12);
        end
        add_run(20, 70, 12);
        repeat (40) pick_random();
        drain_results();

        while (requests_sent < REQUEST_GOAL) begin
            if ($urandom_range(0, 4) != 0) begin
                issue_request(MODE_CLEAR, $urandom(), $urandom(), $urandom());
            end
            add_run($urandom_range(1, 40), 65, $urandom_range(0, 20));
            repeat ($urandom_range(0, 25)) pick_random();
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (30) @(posedge aclk);
        if (table_model.mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
